>>> src/vadpcm_pkg.sv
package vadpcm_pkg;

  // frame geometry
  localparam int LaneCount    = 8;
  localparam int FrameLen     = 16;
  localparam int SlotsPerPred = 16;

  // input item modes
  localparam logic [1:0] ModeCoef  = 2'd0;
  localparam logic [1:0] ModeHist  = 2'd1;
  localparam logic [1:0] ModeFrame = 2'd2;

  // configuration register indexes and reset values
  localparam logic [7:0]  RegInputGain   = 8'd0;
  localparam logic [7:0]  RegOutputScale = 8'd1;
  localparam logic [15:0] InputGainRst   = 16'd2048;
  localparam logic [15:0] OutputScaleRst = 16'd32;

  // residual shift is (12 - scale) when positive
  localparam logic [3:0] ResShiftBase = 4'd12;

  // lane sequence steps within one half frame
  localparam logic [3:0] StepOlder   = 4'd0;
  localparam logic [3:0] StepNewer   = 4'd1;
  localparam logic [3:0] StepGain    = 4'd2;
  localparam logic [3:0] StepBcast0  = 4'd3;
  localparam logic [3:0] StepMacLast = 4'd9;
  localparam logic [3:0] StepScale   = 4'd11;
  localparam logic [3:0] StepSat     = 4'd12;
  localparam logic [3:0] StepDone    = 4'd13;

  // operand pair a lane multiplies in one step
  typedef enum logic [1:0] {
    SelOlder,
    SelNewer,
    SelGain,
    SelBcast
  } lane_sel_e;

  typedef struct packed {
    logic      mul_en;
    logic      first;
    lane_sel_e sel;
    logic      scale_en;
    logic      sat_en;
  } lane_ctl_t;

  // capture of one half frame of lane results
  typedef struct packed {
    logic en;
    logic half;
  } cap_t;

  // residual placed at the top of a halfword, then scaled down
  function automatic logic signed [15:0] res_decode(input logic [3:0] nib,
                                                    input logic [3:0] scale);
    logic signed [15:0] base;
    base = {nib, 12'b0};
    if (scale < ResShiftBase) begin
      return base >>> (ResShiftBase - scale);
    end
    return base;
  endfunction

  // clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

>>> src/vadpcm_lane.sv
module vadpcm_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vadpcm_pkg::lane_ctl_t    ctl_i,
  input  logic signed [15:0]       coef_older_i,
  input  logic signed [15:0]       coef_newer_i,
  input  logic signed [15:0]       coef_bcast_i,
  input  logic signed [15:0]       res_i,
  input  logic signed [15:0]       older_i,
  input  logic signed [15:0]       newer_i,
  input  logic signed [15:0]       gain_i,
  input  logic signed [15:0]       oscale_i,
  output logic signed [15:0]       sample_o
);

  logic signed [15:0] op_a, op_b;
  logic signed [31:0] prod_d, prod_q;
  logic signed [31:0] acc_d, acc_q;
  logic signed [47:0] scaled_d, scaled_q;
  logic signed [15:0] sample_q;
  logic               acc_en_q, first_q;

  // operand selection for this step
  always_comb begin
    unique case (ctl_i.sel)
      vadpcm_pkg::SelOlder: begin
        op_a = coef_older_i;
        op_b = older_i;
      end
      vadpcm_pkg::SelNewer: begin
        op_a = coef_newer_i;
        op_b = newer_i;
      end
      vadpcm_pkg::SelGain: begin
        op_a = res_i;
        op_b = gain_i;
      end
      default: begin
        op_a = coef_bcast_i;
        op_b = res_i;
      end
    endcase
  end

  // product, wrapping accumulate, output scaling
  assign prod_d   = 32'(op_a) * 32'(op_b);
  assign acc_d    = first_q ? prod_q : acc_q + prod_q;
  assign scaled_d = 48'(acc_q) * 48'(oscale_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      acc_en_q <= ctl_i.mul_en;
      first_q  <= ctl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (acc_en_q) begin
      acc_q <= acc_d;
    end
    if (ctl_i.scale_en) begin
      scaled_q <= scaled_d;
    end
    if (ctl_i.sat_en) begin
      sample_q <= vadpcm_pkg::sat16($signed(scaled_q[47:16]));
    end
  end

  assign sample_o = sample_q;

endmodule

>>> src/vadpcm_merge.sv
module vadpcm_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vadpcm_pkg::cap_t    cap_i,
  input  logic signed [15:0]  lane_smp_i [vadpcm_pkg::LaneCount],
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  sample_o,
  output logic [3:0]          sample_index_o,
  output logic                last_of_frame_o
);

  localparam logic [3:0] LastIdx = 4'(vadpcm_pkg::FrameLen - 1);

  logic signed [15:0] obuf_q [vadpcm_pkg::FrameLen];
  logic               emit_q;
  logic [3:0]         ocnt_q;
  logic               out_acc;

  assign out_acc = emit_q && out_ready_i;

  // collect lane results, first half then second half
  always_ff @(posedge clk_i) begin
    if (cap_i.en) begin
      for (int j = 0; j < vadpcm_pkg::LaneCount; j++) begin
        if (cap_i.half) begin
          obuf_q[vadpcm_pkg::LaneCount + j] <= lane_smp_i[j];
        end else begin
          obuf_q[j] <= lane_smp_i[j];
        end
      end
    end
  end

  // emission of the sixteen samples, one transaction each
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      ocnt_q <= '0;
    end else if (cap_i.en && cap_i.half) begin
      emit_q <= 1'b1;
      ocnt_q <= '0;
    end else if (out_acc) begin
      if (ocnt_q == LastIdx) begin
        emit_q <= 1'b0;
      end
      ocnt_q <= ocnt_q + 4'd1;
    end
  end

  assign busy_o          = emit_q;
  assign out_valid_o     = emit_q;
  assign sample_o        = obuf_q[ocnt_q];
  assign sample_index_o  = ocnt_q;
  assign last_of_frame_o = (ocnt_q == LastIdx);

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_of_frame_o |=> !out_valid_o)
    else $error("emission continues after last sample");

  a_cap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_i.en |-> !out_valid_o)
    else $error("capture overwrites samples being emitted");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_i.en && cap_i.half |=> out_valid_o && sample_index_o == 4'd0)
    else $error("frame emission does not start at sample zero");

endmodule

>>> src/vadpcm_frame_decoder_unit.sv
// VADPCM frame decoder.
// Input channel (in_valid_i/in_ready_o): mode 0 writes one codebook entry,
// mode 1 loads the two history samples, mode 2 decodes one 9-byte frame,
// mode 3 is dropped. Modes 0, 1 and 3 give no output.
// A frame first copies its predictor's 16 coefficients from the codebook
// memory into the lanes' row registers (one read per cycle), then eight
// lanes each run a 10-step multiply-accumulate, a scale multiply and a saturate
// per half frame, for each of the two halves.
// The first sample is valid once the second half is captured; the input
// side is not ready while a frame is in progress, and a new item is taken
// once that work is done.
// Output channel (out_valid_o/out_ready_i) gives 16 samples, one per cycle
// when not stalled, from a result buffer; emission overlaps the next frame.
// If the receiver stalls, the next frame's lanes hold their results until
// the buffer is free.
// Configuration (cfg_*): index 0 input gain, index 1 output scale; always
// ready. Reset clears history to zero and sets gain 2048, scale 32; the
// codebook is not cleared and must be written before it is used.
module vadpcm_frame_decoder_unit #(
  parameter int unsigned NumPredictors = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         coef_index_i,
  input  logic signed [15:0] coef_value_i,
  input  logic signed [15:0] older_sample_i,
  input  logic signed [15:0] newer_sample_i,
  input  logic [7:0]         frame_header_i,
  input  logic [63:0]        frame_nibbles_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic [3:0]         sample_index_o,
  output logic               last_of_frame_o
);

  localparam int         BookSize  = NumPredictors * vadpcm_pkg::SlotsPerPred;
  localparam int         BookAw    = $clog2(BookSize);
  localparam int         Lanes     = vadpcm_pkg::LaneCount;
  localparam logic [4:0] NumPredW  = 5'(NumPredictors);
  localparam logic [8:0] BookSizeW = 9'(BookSize);
  localparam logic [4:0] LoadLast  = 5'(vadpcm_pkg::SlotsPerPred);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StMac  = 2'd2;

  logic [1:0]         state_q;
  logic [4:0]         cnt_q;
  logic [3:0]         step_q;
  logic               half_q;
  logic [3:0]         pred_q, scale_q;
  logic               pred_ok_q;
  logic [63:0]        nib_q;
  logic signed [15:0] hist_older_q, hist_newer_q;
  logic signed [15:0] gain_q, oscale_q;
  logic signed [15:0] coef_q [vadpcm_pkg::SlotsPerPred];
  logic signed [15:0] rs_q [Lanes];
  logic signed [15:0] res_half [Lanes];
  logic signed [15:0] lane_smp [Lanes];
  logic signed [15:0] book_mem [BookSize];
  logic signed [15:0] rd_data_q;
  logic               rd_valid_q;
  logic               rd_en, book_we, in_acc, emit_busy;
  logic [31:0]        nib_half;
  logic [2:0]         bidx;
  logic signed [15:0] coef_bcast;
  vadpcm_pkg::lane_ctl_t ctl;
  vadpcm_pkg::cap_t      cap;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign book_we     = in_acc && (mode_i == vadpcm_pkg::ModeCoef) &&
                       ({1'b0, coef_index_i} < BookSizeW);
  assign rd_en       = (state_q == StLoad) && (cnt_q < LoadLast) && pred_ok_q;

  // codebook memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (book_we) begin
      book_mem[BookAw'(coef_index_i)] <= coef_value_i;
    end
    if (rd_en) begin
      rd_data_q <= book_mem[BookAw'({pred_q, cnt_q[3:0]})];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= vadpcm_pkg::InputGainRst;
      oscale_q <= vadpcm_pkg::OutputScaleRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vadpcm_pkg::RegInputGain:   gain_q   <= cfg_data_i;
        vadpcm_pkg::RegOutputScale: oscale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer: idle, coefficient load, lane passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      step_q       <= '0;
      half_q       <= 1'b0;
      rd_valid_q   <= 1'b0;
      hist_older_q <= '0;
      hist_newer_q <= '0;
    end else begin
      rd_valid_q <= (state_q == StLoad) && (cnt_q < LoadLast);
      unique case (state_q)
        StIdle: begin
          if (in_acc && mode_i == vadpcm_pkg::ModeHist) begin
            hist_older_q <= older_sample_i;
            hist_newer_q <= newer_sample_i;
          end
          if (in_acc && mode_i == vadpcm_pkg::ModeFrame) begin
            state_q <= StLoad;
            cnt_q   <= '0;
            half_q  <= 1'b0;
          end
        end
        StLoad: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == LoadLast) begin
            state_q <= StMac;
            step_q  <= vadpcm_pkg::StepOlder;
          end
        end
        StMac: begin
          if (step_q != vadpcm_pkg::StepDone) begin
            step_q <= step_q + 4'd1;
          end else if (!emit_busy) begin
            hist_older_q <= lane_smp[Lanes-2];
            hist_newer_q <= lane_smp[Lanes-1];
            step_q       <= vadpcm_pkg::StepOlder;
            if (half_q) begin
              state_q <= StIdle;
            end else begin
              half_q <= 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // frame payload latched at acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == vadpcm_pkg::ModeFrame) begin
      pred_q    <= frame_header_i[3:0];
      scale_q   <= frame_header_i[7:4];
      pred_ok_q <= ({1'b0, frame_header_i[3:0]} < NumPredW);
      nib_q     <= frame_nibbles_i;
    end
  end

  // coefficient row registers fill by shifting in memory reads
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      for (int i = 0; i < vadpcm_pkg::SlotsPerPred - 1; i++) begin
        coef_q[i] <= coef_q[i+1];
      end
      coef_q[vadpcm_pkg::SlotsPerPred-1] <= pred_ok_q ? rd_data_q : '0;
    end
  end

  // residuals of the current half; shifted so lane j sees res[j-m] at step m+2
  assign nib_half = half_q ? nib_q[31:0] : nib_q[63:32];

  for (genvar j = 0; j < Lanes; j++) begin : g_res
    assign res_half[j] = vadpcm_pkg::res_decode(nib_half[(Lanes-1-j)*4 +: 4], scale_q);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMac && step_q == vadpcm_pkg::StepOlder) begin
      rs_q <= res_half;
    end else if (state_q == StMac && step_q >= vadpcm_pkg::StepGain &&
                 step_q < vadpcm_pkg::StepMacLast) begin
      rs_q[0] <= '0;
      for (int j = 1; j < Lanes; j++) begin
        rs_q[j] <= rs_q[j-1];
      end
    end
  end

  // lane control, shared by all lanes
  assign bidx       = 3'(step_q - vadpcm_pkg::StepBcast0);
  assign coef_bcast = coef_q[{1'b1, bidx}];

  always_comb begin
    ctl.mul_en   = (state_q == StMac) && (step_q <= vadpcm_pkg::StepMacLast);
    ctl.first    = (state_q == StMac) && (step_q == vadpcm_pkg::StepOlder);
    ctl.scale_en = (state_q == StMac) && (step_q == vadpcm_pkg::StepScale);
    ctl.sat_en   = (state_q == StMac) && (step_q == vadpcm_pkg::StepSat);
    priority if (step_q == vadpcm_pkg::StepOlder) begin
      ctl.sel = vadpcm_pkg::SelOlder;
    end else if (step_q == vadpcm_pkg::StepNewer) begin
      ctl.sel = vadpcm_pkg::SelNewer;
    end else if (step_q == vadpcm_pkg::StepGain) begin
      ctl.sel = vadpcm_pkg::SelGain;
    end else begin
      ctl.sel = vadpcm_pkg::SelBcast;
    end
  end

  for (genvar j = 0; j < Lanes; j++) begin : g_lane
    vadpcm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .coef_older_i (coef_q[j]),
      .coef_newer_i (coef_q[Lanes+j]),
      .coef_bcast_i (coef_bcast),
      .res_i        (rs_q[j]),
      .older_i      (hist_older_q),
      .newer_i      (hist_newer_q),
      .gain_i       (gain_q),
      .oscale_i     (oscale_q),
      .sample_o     (lane_smp[j])
    );
  end

  // hand each finished half to the result buffer
  assign cap.en   = (state_q == StMac) && (step_q == vadpcm_pkg::StepDone) && !emit_busy;
  assign cap.half = half_q;

  vadpcm_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_i           (cap),
    .lane_smp_i      (lane_smp),
    .busy_o          (emit_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sample_o        (sample_o),
    .sample_index_o  (sample_index_o),
    .last_of_frame_o (last_of_frame_o)
  );

  a_load_to_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad && cnt_q == LoadLast |=>
      state_q == StMac && step_q == vadpcm_pkg::StepOlder)
    else $error("coefficient load does not hand over to the lanes");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMac |-> step_q <= vadpcm_pkg::StepDone)
    else $error("lane step counter out of range");

  a_hist_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap.en |=> hist_newer_q == $past(lane_smp[Lanes-1]) &&
               hist_older_q == $past(lane_smp[Lanes-2]))
    else $error("history not taken from last two samples of the half");

endmodule
